// ===== rtl/rgbhsl_pkg.sv =====
// package with widths, codes, pipeline types and the long division step for the rgb to hsl block
package rgbhsl_pkg;

  localparam int unsigned HUE_FRAC_BITS_DEF = 6;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned HUE_W = 15;
  localparam int unsigned SAT_W = 16;
  localparam int unsigned LIT_W = 9;

  localparam int unsigned QUO_W           = 16;
  localparam int unsigned DIV_STAGES      = 4;
  localparam int unsigned STEPS_PER_STAGE = QUO_W / DIV_STAGES;
  localparam int unsigned DVD_W           = CH_W + QUO_W;

  localparam int unsigned SAT_SCALE   = 65535;
  localparam int unsigned LIT_FULL    = 510;
  localparam int unsigned CH_FULL     = 255;
  localparam int unsigned HUE_SECTOR  = 60;
  localparam int unsigned HUE_GREEN   = 120;
  localparam int unsigned HUE_BLUE    = 240;
  localparam int unsigned HUE_WRAP    = 360;

  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_e;

  typedef struct packed {
    logic [CH_W-1:0]  divisor;
    logic [CH_W-1:0]  rem;
    logic [QUO_W-1:0] bits;
  } div_t;

  typedef struct packed {
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    sector_e           sec;
    logic signed [CH_W:0] diff;
  } ext_t;

  typedef struct packed {
    sector_e          sec;
    logic             neg;
    logic             gray;
    logic [LIT_W-1:0] sum;
    div_t             sat;
    div_t             hue;
  } work_t;

  // restoring division, one quotient bit per step, dividend bits shift out as quotient shifts in
  function automatic div_t div_steps(div_t din);
    div_t          dv;
    logic [CH_W:0] part;
    dv = din;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      part = {dv.rem, dv.bits[QUO_W-1]};
      if (part >= {1'b0, dv.divisor}) begin
        part    = part - {1'b0, dv.divisor};
        dv.bits = {dv.bits[QUO_W-2:0], 1'b1};
      end else begin
        dv.bits = {dv.bits[QUO_W-2:0], 1'b0};
      end
      dv.rem = part[CH_W-1:0];
    end
    return dv;
  endfunction

endpackage

// ===== rtl/rgbhsl_if.sv =====
// valid/ready channel interfaces for rgb pixel beats and hsl result beats
interface rgbhsl_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rgbhsl_pkg::CH_W-1:0] red;
  logic [rgbhsl_pkg::CH_W-1:0] green;
  logic [rgbhsl_pkg::CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbhsl_hsl_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsl_pkg::HUE_W-1:0] hue;
  logic [rgbhsl_pkg::SAT_W-1:0] saturation;
  logic [rgbhsl_pkg::LIT_W-1:0] lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

// ===== rtl/rgb_to_hsl_converter.sv =====
// rgb to hsl converter top level, seven stage pipeline
// each pixel beat leaves as a result beat, with the result held in the output register
// one pixel per clock unless stalled; the two long divisions retire 4 quotient bits per stage
// a stall holds each occupied stage; empty stages keep filling behind it
// reset clears only the stage valid bits, payload registers are not reset
module rgb_to_hsl_converter #(
  parameter int unsigned HUE_FRAC_BITS = rgbhsl_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rgbhsl_pix_if.sink          pix_i,
  rgbhsl_hsl_if.source        hsl_o
);

  localparam int unsigned NStg      = 3 + rgbhsl_pkg::DIV_STAGES;
  localparam int unsigned OutStg    = NStg - 1;
  localparam int unsigned HueStep   = rgbhsl_pkg::HUE_SECTOR << HUE_FRAC_BITS;
  localparam int unsigned HueAccRaw = $clog2((rgbhsl_pkg::HUE_WRAP << HUE_FRAC_BITS) + 1);
  localparam int unsigned HueAccW   = (HueAccRaw > rgbhsl_pkg::HUE_W) ? HueAccRaw
                                                                      : rgbhsl_pkg::HUE_W;
  localparam int unsigned DvdW      = rgbhsl_pkg::DVD_W;
  localparam int unsigned ChW       = rgbhsl_pkg::CH_W;
  localparam int unsigned QuoW      = rgbhsl_pkg::QUO_W;
  localparam int unsigned LitW      = rgbhsl_pkg::LIT_W;

  logic [NStg:0]   adv;
  logic [NStg-1:0] valid_q;
  logic [NStg-1:0] valid_d;

  rgbhsl_pkg::ext_t  ext_d;
  rgbhsl_pkg::ext_t  ext_q;
  rgbhsl_pkg::work_t work_d [0:rgbhsl_pkg::DIV_STAGES];
  rgbhsl_pkg::work_t work_q [0:rgbhsl_pkg::DIV_STAGES];

  logic [rgbhsl_pkg::HUE_W-1:0] hue_d, hue_q;
  logic [rgbhsl_pkg::SAT_W-1:0] sat_d, sat_q;
  logic [LitW-1:0]              lit_d, lit_q;

  // stage ready chain
  always_comb begin
    adv[NStg] = hsl_o.ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign pix_i.ready = adv[0];

  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      if (adv[k]) begin
        valid_d[k] = (k == 0) ? pix_i.valid : valid_q[(k == 0) ? 0 : k - 1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stage 0: max, min and sector
  always_comb begin
    ext_d.mx = pix_i.red;
    ext_d.mn = pix_i.red;
    if (pix_i.green > ext_d.mx) ext_d.mx = pix_i.green;
    if (pix_i.blue > ext_d.mx) ext_d.mx = pix_i.blue;
    if (pix_i.green < ext_d.mn) ext_d.mn = pix_i.green;
    if (pix_i.blue < ext_d.mn) ext_d.mn = pix_i.blue;
    priority if (ext_d.mx == pix_i.red) begin
      ext_d.sec  = rgbhsl_pkg::SEC_RED;
      ext_d.diff = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
    end else if (ext_d.mx == pix_i.green) begin
      ext_d.sec  = rgbhsl_pkg::SEC_GREEN;
      ext_d.diff = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
    end else begin
      ext_d.sec  = rgbhsl_pkg::SEC_BLUE;
      ext_d.diff = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ext_q <= ext_d;
    end
  end

  // stage 1: spread, denominator and dividends, then the division stages behind it
  logic [LitW-1:0] sum_c;
  logic [LitW-1:0] rsum_c;
  logic [ChW-1:0]  spread_c;
  logic [ChW-1:0]  den_c;
  logic [ChW:0]    negd_c;
  logic [ChW-1:0]  mag_c;
  logic [DvdW-1:0] sat_dvd_c;
  logic [DvdW-1:0] hue_dvd_c;

  always_comb begin
    sum_c     = LitW'(ext_q.mx) + LitW'(ext_q.mn);
    rsum_c    = LitW'(rgbhsl_pkg::LIT_FULL) - sum_c;
    spread_c  = ext_q.mx - ext_q.mn;
    den_c     = (sum_c <= LitW'(rgbhsl_pkg::CH_FULL)) ? sum_c[ChW-1:0] : rsum_c[ChW-1:0];
    negd_c    = -ext_q.diff;
    mag_c     = ext_q.diff[ChW] ? negd_c[ChW-1:0] : ext_q.diff[ChW-1:0];
    sat_dvd_c = DvdW'(spread_c) * DvdW'(rgbhsl_pkg::SAT_SCALE);
    hue_dvd_c = DvdW'(mag_c) * DvdW'(HueStep);

    work_d[0].sec         = ext_q.sec;
    work_d[0].neg         = ext_q.diff[ChW];
    work_d[0].gray        = (spread_c == '0);
    work_d[0].sum         = sum_c;
    work_d[0].sat.divisor = den_c;
    work_d[0].sat.rem     = sat_dvd_c[DvdW-1:QuoW];
    work_d[0].sat.bits    = sat_dvd_c[QuoW-1:0];
    work_d[0].hue.divisor = spread_c;
    work_d[0].hue.rem     = hue_dvd_c[DvdW-1:QuoW];
    work_d[0].hue.bits    = hue_dvd_c[QuoW-1:0];

    for (int j = 1; j <= rgbhsl_pkg::DIV_STAGES; j++) begin
      work_d[j]     = work_q[j-1];
      work_d[j].sat = rgbhsl_pkg::div_steps(work_q[j-1].sat);
      work_d[j].hue = rgbhsl_pkg::div_steps(work_q[j-1].hue);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= rgbhsl_pkg::DIV_STAGES; j++) begin
      if (adv[1+j]) begin
        work_q[j] <= work_d[j];
      end
    end
  end

  // last stage: hue from sector base, output register
  rgbhsl_pkg::work_t fin;
  logic [HueAccW-1:0] base_c;
  logic [HueAccW-1:0] hue_full_c;

  always_comb begin
    fin = work_q[rgbhsl_pkg::DIV_STAGES];
    unique case (fin.sec)
      rgbhsl_pkg::SEC_RED:   base_c = fin.neg ? HueAccW'(rgbhsl_pkg::HUE_WRAP) : '0;
      rgbhsl_pkg::SEC_GREEN: base_c = HueAccW'(rgbhsl_pkg::HUE_GREEN);
      rgbhsl_pkg::SEC_BLUE:  base_c = HueAccW'(rgbhsl_pkg::HUE_BLUE);
      default:               base_c = '0;
    endcase
    base_c = base_c << HUE_FRAC_BITS;
    if (fin.neg) begin
      hue_full_c = base_c - HueAccW'(fin.hue.bits) - HueAccW'(fin.hue.rem != '0);
    end else begin
      hue_full_c = base_c + HueAccW'(fin.hue.bits);
    end
    hue_d = fin.gray ? '0 : hue_full_c[rgbhsl_pkg::HUE_W-1:0];
    sat_d = fin.gray ? '0 : fin.sat.bits;
    lit_d = fin.sum;
  end

  always_ff @(posedge clk_i) begin
    if (adv[OutStg]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      lit_q <= lit_d;
    end
  end

  assign hsl_o.valid      = valid_q[OutStg];
  assign hsl_o.hue        = hue_q;
  assign hsl_o.saturation = sat_q;
  assign hsl_o.lightness  = lit_q;

`ifndef NO_ASSERTIONS
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> valid_q[0])
    else $error("accepted pixel beat did not enter the first stage");

  a_gray_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsl_o.valid && (hsl_o.saturation == '0)) |-> (hsl_o.hue == '0))
    else $error("zero saturation with nonzero hue");

  a_sat_light : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsl_o.valid && (hsl_o.saturation != '0)) |->
      ((hsl_o.lightness != '0) && (hsl_o.lightness != LitW'(rgbhsl_pkg::LIT_FULL))))
    else $error("saturated result at black or white lightness");

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsl_o.valid |-> ((HUE_FRAC_BITS > 6) ||
      (32'(hsl_o.hue) < (rgbhsl_pkg::HUE_WRAP << HUE_FRAC_BITS))))
    else $error("hue at or above full circle");
`endif

endmodule
